### sv/brb_pkg.sv
// Package for the byte ring buffer burst unit.
// Holds opcodes, status codes, command kinds, field widths and the command record.
// No dependencies.
package brb_pkg;

   localparam int OP_W              = 2;
   localparam int LEN_W             = 9;
   localparam int DATA_W            = 8;
   localparam int STATUS_W          = 2;
   localparam int CNT_W             = 9;
   localparam int CAP_MAX           = (1 << CNT_W) - 1;
   localparam int IDX_MAX_W         = CNT_W;
   localparam int DEFAULT_MAX_DEPTH = 256;
   localparam int CAP_RESET         = 256;
   localparam int QUEUE_DEPTH       = 4;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_RETRIEVE = 2'd1,
      OP_PEEK     = 2'd2,
      OP_RESET    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_BAD_PARAM  = 2'd1,
      ST_OUT_OF_MEM = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_kind_type;

   // One classified transaction, handed from the front to the back.
   typedef struct packed {
      cmd_kind_type          kind;
      logic [IDX_MAX_W-1:0]  addr;
      logic [DATA_W-1:0]     data;
      status_type            status;
      logic [CNT_W-1:0]      used;
      logic [CNT_W-1:0]      free;
      logic                  done;
   } cmd_type;

endpackage

### sv/brb_ifs.sv
// Channel interfaces of the byte ring buffer burst unit.
// Depends on brb_pkg for field widths.
interface brb_req_if;
   logic                        valid;
   logic                        ready;
   logic [brb_pkg::OP_W-1:0]    opcode;
   logic                        first_of_burst;
   logic [brb_pkg::LEN_W-1:0]   request_length;
   logic [brb_pkg::DATA_W-1:0]  data_byte;

   modport source (output valid, opcode, first_of_burst, request_length, data_byte,
                   input ready);
   modport sink   (input valid, opcode, first_of_burst, request_length, data_byte,
                   output ready);
endinterface

interface brb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [brb_pkg::DATA_W-1:0]    read_byte;
   logic [brb_pkg::STATUS_W-1:0]  status;
   logic [brb_pkg::CNT_W-1:0]     used_count;
   logic [brb_pkg::CNT_W-1:0]     free_count;
   logic                          burst_done;

   modport source (output valid, read_byte, status, used_count, free_count, burst_done,
                   input ready);
   modport sink   (input valid, read_byte, status, used_count, free_count, burst_done,
                   output ready);
endinterface

### sv/brb_cmd_queue.sv
// Short command queue between the front and the back of the ring buffer unit.
// Depends on brb_pkg for cmd_type and QUEUE_DEPTH.
module brb_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brb_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output brb_pkg::cmd_type  head_cmd
);
   import brb_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");

endmodule

### sv/brb_front.sv
// Front of the ring buffer unit: takes request transactions, tracks bursts, indices
// and counts, and turns each item into a memory command. Depends on brb_pkg.
module brb_front #(
   parameter int MAX_DEPTH = brb_pkg::DEFAULT_MAX_DEPTH,
   parameter int MEM_DEPTH = brb_pkg::DEFAULT_MAX_DEPTH,
   parameter int IDX_W     = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   brb_req_if.sink                    req_chan,
   input  logic                       csr_wr_en,
   input  logic [brb_pkg::CNT_W-1:0]  csr_wr_data,
   input  logic                       q_full,
   output logic                       push,
   output brb_pkg::cmd_type           push_cmd
);
   import brb_pkg::*;

   localparam logic [CNT_W-1:0] CAP_INIT =
      CNT_W'((CAP_RESET > MEM_DEPTH) ? MEM_DEPTH : CAP_RESET);

   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] peek_ff, peek_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             acc_ff, acc_in;
   op_type           bop_ff, bop_in;
   logic [CNT_W-1:0] cap_ff, cap_in;

   op_type           op;
   logic             move;
   logic [LEN_W-1:0] rem_cur;
   logic             acc_cur;
   op_type           bop_cur;
   logic [IDX_W-1:0] peek_cur;
   logic [CNT_W-1:0] avail;
   logic [CNT_W-1:0] cap_wr;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= cap) ? '0 : IDX_W'(nxt);
   endfunction

   assign op             = op_type'(req_chan.opcode);
   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   // Clamp the written capacity into 1..MAX_DEPTH.
   always_comb begin
      cap_wr = csr_wr_data;
      if (csr_wr_data == '0) begin
         cap_wr = CNT_W'(1);
      end else if (32'(csr_wr_data) > MAX_DEPTH) begin
         cap_wr = CNT_W'(MEM_DEPTH);
      end
   end

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      cap_in    = cap_ff;
      rem_cur   = rem_ff;
      acc_cur   = acc_ff;
      bop_cur   = bop_ff;
      peek_cur  = peek_ff;
      move      = 1'b0;
      avail     = (op == OP_INSERT) ? (cap_ff - count_ff) : count_ff;

      push_cmd        = '0;
      push_cmd.kind   = CMD_NONE;
      push_cmd.status = ST_OK;
      push_cmd.data   = req_chan.data_byte;

      if (op == OP_RESET) begin
         wr_idx_in     = '0;
         rd_idx_in     = '0;
         count_in      = '0;
         rem_cur       = '0;
         acc_cur       = 1'b0;
         bop_cur       = OP_INSERT;
         peek_cur      = '0;
         push_cmd.done = 1'b1;
      end else if (req_chan.first_of_burst) begin
         bop_cur = op;
         if (req_chan.request_length == '0) begin
            rem_cur         = '0;
            acc_cur         = 1'b0;
            push_cmd.status = ST_BAD_PARAM;
            push_cmd.done   = 1'b1;
         end else begin
            acc_cur  = (req_chan.request_length <= avail);
            rem_cur  = req_chan.request_length;
            peek_cur = rd_idx_ff;
            move     = 1'b1;
         end
      end else if (rem_ff != '0) begin
         move = 1'b1;
      end

      if (move) begin
         if (acc_cur) begin
            case (bop_cur)
               OP_INSERT: begin
                  if (count_ff < cap_ff) begin
                     push_cmd.kind = CMD_WRITE;
                     push_cmd.addr = IDX_MAX_W'(wr_idx_ff);
                     wr_idx_in     = advance(wr_idx_ff, cap_ff);
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
               OP_RETRIEVE: begin
                  if (count_ff != '0) begin
                     push_cmd.kind = CMD_READ;
                     push_cmd.addr = IDX_MAX_W'(rd_idx_ff);
                     rd_idx_in     = advance(rd_idx_ff, cap_ff);
                     count_in      = count_ff - CNT_W'(1);
                  end
               end
               default: begin
                  push_cmd.kind = CMD_READ;
                  push_cmd.addr = IDX_MAX_W'(peek_cur);
                  peek_cur      = advance(peek_cur, cap_ff);
               end
            endcase
         end else begin
            push_cmd.status = ST_OUT_OF_MEM;
         end
         rem_cur = rem_cur - LEN_W'(1);
         if (rem_cur == '0) begin
            push_cmd.done = 1'b1;
            acc_cur       = 1'b0;
         end
      end

      rem_in        = rem_cur;
      acc_in        = acc_cur;
      bop_in        = bop_cur;
      peek_in       = peek_cur;
      push_cmd.used = count_in;
      push_cmd.free = cap_ff - count_in;

      if (!push) begin
         wr_idx_in = wr_idx_ff;
         rd_idx_in = rd_idx_ff;
         count_in  = count_ff;
         rem_in    = rem_ff;
         acc_in    = acc_ff;
         bop_in    = bop_ff;
         peek_in   = peek_ff;
      end

      // A capacity write empties the buffer and drops any burst.
      if (csr_wr_en) begin
         cap_in    = cap_wr;
         wr_idx_in = '0;
         rd_idx_in = '0;
         count_in  = '0;
         rem_in    = '0;
         acc_in    = 1'b0;
         bop_in    = OP_INSERT;
         peek_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         peek_ff   <= '0;
         count_ff  <= '0;
         rem_ff    <= '0;
         acc_ff    <= 1'b0;
         bop_ff    <= OP_INSERT;
         cap_ff    <= CAP_INIT;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         peek_ff   <= peek_in;
         count_ff  <= count_in;
         rem_ff    <= rem_in;
         acc_ff    <= acc_in;
         bop_ff    <= bop_in;
         cap_ff    <= cap_in;
      end
   end

   a_count_fits: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("stored count exceeds capacity");

   a_accepted_has_bytes: assert property (@(posedge clock) disable iff (reset)
      acc_ff |-> (rem_ff != '0))
      else $error("accepted burst with no bytes left");

   a_indices_in_ring: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(wr_idx_ff) < cap_ff) && (CNT_W'(rd_idx_ff) < cap_ff))
      else $error("ring index beyond capacity");

endmodule

### sv/brb_back.sv
// Back of the ring buffer unit: executes queued commands on the byte store and
// holds the response in an output register. Depends on brb_pkg.
module brb_back #(
   parameter int MEM_DEPTH = brb_pkg::DEFAULT_MAX_DEPTH,
   parameter int IDX_W     = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  brb_pkg::cmd_type  head_cmd,
   output logic              pop,
   brb_rsp_if.source         rsp_chan
);
   import brb_pkg::*;

   logic [DATA_W-1:0] store_mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   cmd_type           out_cmd_ff;
   logic              out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]  mem_addr;

   // Advance when the output register is free or being drained.
   assign pop          = !q_empty && (!out_valid_ff || rsp_chan.ready);
   assign mem_addr     = head_cmd.addr[IDX_W-1:0];
   assign out_valid_in = pop || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_cmd_ff <= head_cmd;
         rd_data_ff <= store_mem[mem_addr];
         if (head_cmd.kind == CMD_WRITE) begin
            store_mem[mem_addr] <= head_cmd.data;
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.read_byte  = (out_cmd_ff.kind == CMD_READ) ? rd_data_ff : '0;
   assign rsp_chan.status     = out_cmd_ff.status;
   assign rsp_chan.used_count = out_cmd_ff.used;
   assign rsp_chan.free_count = out_cmd_ff.free;
   assign rsp_chan.burst_done = out_cmd_ff.done;

endmodule

### sv/byte_ring_buffer_burst_unit.sv
// Byte ring buffer with all-or-nothing insert, retrieve and peek bursts.
// A response passes the command queue and then the output register in the back.
// Throughput: one transaction per cycle while the queue has room; single store port.
// A four-entry command queue lets the front keep accepting while responses stall.
// Reset (synchronous) clears indices, count, burst state, queue and output valid and
// sets capacity to 256 (or MAX_DEPTH if smaller); store contents are not cleared.
module byte_ring_buffer_burst_unit #(
   parameter int MAX_DEPTH = brb_pkg::DEFAULT_MAX_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   brb_req_if.sink                    req_chan,
   brb_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [brb_pkg::CNT_W-1:0]  csr_wr_data
);
   import brb_pkg::*;

   localparam int MEM_DEPTH = (MAX_DEPTH < CAP_MAX) ? MAX_DEPTH : CAP_MAX;
   localparam int IDX_W     = $clog2(MEM_DEPTH);

   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   brb_front #(
      .MAX_DEPTH (MAX_DEPTH),
      .MEM_DEPTH (MEM_DEPTH),
      .IDX_W     (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   brb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   brb_back #(
      .MEM_DEPTH (MEM_DEPTH),
      .IDX_W     (IDX_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head_cmd (head_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### bench/brb_ring_checker.sv
// Scoreboard for the byte ring buffer burst unit: keeps its own ring model, predicts one
// response per request transaction and compares responses in order, field by field.
// Depends on brb_pkg and the channel interfaces in sv/brb_ifs.sv.
`timescale 1ns / 1ps
module brb_ring_checker (
   input  logic                      clock,
   input  logic                      reset,
   brb_req_if                        req_mon,
   brb_rsp_if                        rsp_mon,
   input  logic                      csr_wr_en,
   input  logic [brb_pkg::CNT_W-1:0] csr_wr_data,
   output int                        fail_count,
   output int                        pending,
   output int                        used_level,
   output int                        n_checked,
   output int                        n_bad,
   output int                        n_oom,
   output int                        n_done
);
   import brb_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] rbyte;
      status_type        status;
      logic [CNT_W-1:0]  used;
      logic [CNT_W-1:0]  free;
      logic              done;
   } ring_rsp_type;

   logic [DATA_W-1:0] ring_mem [DEFAULT_MAX_DEPTH];
   logic [7:0]        wr_idx, rd_idx, peek_cur;
   logic [CNT_W-1:0]  ring_cap, stored, remaining;
   logic              accepted;
   op_type            burst_op;
   ring_rsp_type      pending_rsps [$];

   function automatic logic [7:0] next_slot(input logic [7:0] idx);
      int n;
      n = int'(idx) + 1;
      if (n >= int'(ring_cap)) n = 0;
      return n[7:0];
   endfunction

   function automatic void clear_ring();
      wr_idx    = '0;
      rd_idx    = '0;
      peek_cur  = '0;
      stored    = '0;
      remaining = '0;
      accepted  = 1'b0;
      burst_op  = OP_INSERT;
   endfunction

   function automatic void set_capacity(input logic [CNT_W-1:0] v);
      if (v == '0) ring_cap = CNT_W'(1);
      else if (int'(v) > DEFAULT_MAX_DEPTH) ring_cap = CNT_W'(DEFAULT_MAX_DEPTH);
      else ring_cap = v;
      clear_ring();
   endfunction

   // Advance the ring model by one request transaction and return its response.
   function automatic ring_rsp_type step_ring(input op_type op, input logic is_first,
                                              input logic [LEN_W-1:0] len,
                                              input logic [DATA_W-1:0] dat);
      ring_rsp_type r;
      logic         move;
      int           room;
      r        = '0;
      r.status = ST_OK;
      move     = 1'b0;
      if (op == OP_RESET) begin
         clear_ring();
         r.done = 1'b1;
      end else if (is_first) begin
         burst_op = op;
         if (len == 0) begin
            remaining = '0;
            accepted  = 1'b0;
            r.status  = ST_BAD_PARAM;
            r.done    = 1'b1;
         end else begin
            room      = (op == OP_INSERT) ? int'(ring_cap) - int'(stored) : int'(stored);
            accepted  = (int'(len) <= room);
            remaining = len;
            peek_cur  = rd_idx;
            move      = 1'b1;
         end
      end else if (remaining != 0) begin
         move = 1'b1;
      end

      if (move) begin
         if (accepted) begin
            case (burst_op)
               OP_INSERT: begin
                  if (stored < ring_cap) begin
                     ring_mem[wr_idx] = dat;
                     wr_idx = next_slot(wr_idx);
                     stored++;
                  end
               end
               OP_RETRIEVE: begin
                  if (stored > 0) begin
                     r.rbyte = ring_mem[rd_idx];
                     rd_idx = next_slot(rd_idx);
                     stored--;
                  end
               end
               default: begin
                  // peek walks its own cursor and leaves the count alone
                  r.rbyte  = ring_mem[peek_cur];
                  peek_cur = next_slot(peek_cur);
               end
            endcase
         end else begin
            r.status = ST_OUT_OF_MEM;
         end
         remaining--;
         if (remaining == 0) begin
            r.done   = 1'b1;
            accepted = 1'b0;
         end
      end
      r.used = stored;
      r.free = ring_cap - stored;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                       input logic [CNT_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      ring_rsp_type want;
      if (reset) begin
         set_capacity(CNT_W'(CAP_RESET));
         pending_rsps.delete();
      end else begin
         // retire first: a response never belongs to a request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_rsps.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual byte %0d status %0d",
                        $time, rsp_mon.read_byte, rsp_mon.status);
            end else begin
               want = pending_rsps.pop_front();
               n_checked++;
               check_field("read_byte", CNT_W'(want.rbyte), CNT_W'(rsp_mon.read_byte));
               check_field("status", CNT_W'(want.status), CNT_W'(rsp_mon.status));
               check_field("used_count", want.used, rsp_mon.used_count);
               check_field("free_count", want.free, rsp_mon.free_count);
               check_field("burst_done", CNT_W'(want.done), CNT_W'(rsp_mon.burst_done));
               if (want.status == ST_BAD_PARAM) n_bad++;
               if (want.status == ST_OUT_OF_MEM) n_oom++;
               if (want.done) n_done++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_rsps.push_back(step_ring(op_type'(req_mon.opcode), req_mon.first_of_burst,
                                             req_mon.request_length, req_mon.data_byte));
         if (csr_wr_en) set_capacity(csr_wr_data);
      end
      pending    = pending_rsps.size();
      used_level = int'(stored);
   end

endmodule

### bench/tb_byte_ring_buffer_burst_unit.sv
// Top of the byte ring buffer burst unit testbench: clock, reset, request stimulus,
// response back-pressure and capacity writes; brb_ring_checker does the checking.
// Depends on brb_pkg, sv/brb_ifs.sv, the unit itself and bench/brb_ring_checker.sv.
`timescale 1ns / 1ps
module tb_byte_ring_buffer_burst_unit;
   import brb_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 60;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   int fail_count, pending, used_level, n_checked, n_bad, n_oom, n_done;
   int eff_cap      = CAP_RESET;
   int run_left     = 0;
   int items_sent   = 0;
   int n_settings   = 0;
   int stall_asked  = 0;
   int stall_served = 0;
   int cycle_count  = 0;

   brb_req_if req_chan();
   brb_rsp_if rsp_chan();

   byte_ring_buffer_burst_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   brb_ring_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .used_level  (used_level),
      .n_checked   (n_checked),
      .n_bad       (n_bad),
      .n_oom       (n_oom),
      .n_done      (n_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: change the stall pattern every so often; serve long hold-offs on request.
   initial begin
      int mode, span, hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 160);
         while (span > 0) begin
            @(posedge clock);
            if (stall_served != stall_asked) begin
               stall_served++;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               rsp_chan.ready <= 1'b0;
               hold_left--;
            end else begin
               case (mode)
                  0:       rsp_chan.ready <= 1'b1;
                  1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
                  2:       rsp_chan.ready <= ($urandom_range(0, 9) != 0);
                  default: rsp_chan.ready <= ($urandom_range(0, 5) == 0);
               endcase
            end
            span--;
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one transaction and hold it until the unit takes it; sometimes idle between runs.
   task automatic send_item(input op_type op, input logic is_first,
                            input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] dat);
      int gap;
      if (run_left == 0) begin
         run_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      run_left--;
      req_chan.valid          <= 1'b1;
      req_chan.opcode         <= op;
      req_chan.first_of_burst <= is_first;
      req_chan.request_length <= len;
      req_chan.data_byte      <= dat;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input int v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[CNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      eff_cap = (v == 0) ? 1 : (v > DEFAULT_MAX_DEPTH) ? DEFAULT_MAX_DEPTH : v;
      n_settings++;
   endtask

   // One random burst or single item: mostly bursts sized to fit, plus misfits, noise and cuts.
   task automatic gen_burst();
      int     pick, len, n, lvl, room;
      op_type op;
      pick = $urandom_range(0, 99);
      lvl  = used_level;
      room = eff_cap - lvl;
      if (pick < 4) begin
         send_item(op_type'($urandom_range(0, 2)), 1'b0, LEN_W'($urandom),
                   DATA_W'($urandom));
         items_sent++;
         return;
      end
      if (pick < 8) begin
         send_item(OP_RESET, 1'($urandom), LEN_W'($urandom), DATA_W'($urandom));
         items_sent++;
         return;
      end
      if (pick < 12) begin
         send_item(op_type'($urandom_range(0, 2)), 1'b1, '0, DATA_W'($urandom));
         items_sent++;
         return;
      end
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? OP_INSERT : (pick < 75) ? OP_RETRIEVE : OP_PEEK;
      pick = $urandom_range(0, 9);
      if (op == OP_INSERT) lvl = room;
      if (pick < 7) begin
         len = (lvl > 0) ? $urandom_range(1, (lvl < 12) ? lvl : 12) : $urandom_range(1, 4);
      end else if (pick < 9) begin
         len = lvl + 1 + $urandom_range(0, 2);
      end else begin
         len = $urandom_range(0, 511);
      end
      n = (len == 0) ? 1 : len;
      // cut long bursts short with a new first item, now and then let a mid-size one run out
      if (len > 24 && (len > 80 || $urandom_range(0, 3) != 0)) n = $urandom_range(1, 6);
      send_item(op, 1'b1, LEN_W'(len), DATA_W'($urandom));
      for (int i = 1; i < n; i++)
         send_item(op_type'($urandom_range(0, 2)), 1'b0, LEN_W'($urandom),
                   DATA_W'($urandom));
      items_sent += n;
   endtask

   initial begin
      int cap_plan [11];
      int phase_start;
      cap_plan = '{1, 2, 5, 16, 0, 256, 511, 3, 64, 255, 0};
      cap_plan[10] = $urandom_range(1, 511);

      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.opcode         <= OP_INSERT;
      req_chan.first_of_burst <= 1'b0;
      req_chan.request_length <= '0;
      req_chan.data_byte      <= '0;
      csr_wr_en               <= 1'b0;
      csr_wr_data             <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero lengths, read from empty, stray item
      send_item(OP_INSERT,   1'b1, 9'd0,   8'h00);
      send_item(OP_RETRIEVE, 1'b1, 9'd0,   8'hFF);
      send_item(OP_PEEK,     1'b1, 9'd0,   8'h00);
      send_item(OP_RETRIEVE, 1'b1, 9'd1,   8'h00);
      send_item(OP_PEEK,     1'b0, 9'd5,   8'h3C);
      // insert three, continuing opcodes differ and must be ignored
      send_item(OP_INSERT,   1'b1, 9'd3,   8'h00);
      send_item(OP_RETRIEVE, 1'b0, 9'd511, 8'hFF);
      send_item(OP_PEEK,     1'b0, 9'd0,   8'hA5);
      send_item(OP_PEEK,     1'b1, 9'd2,   8'h00);
      send_item(OP_INSERT,   1'b0, 9'd0,   8'h77);
      send_item(OP_RETRIEVE, 1'b1, 9'd3,   8'h00);
      send_item(OP_INSERT,   1'b0, 9'd0,   8'h00);
      send_item(OP_PEEK,     1'b0, 9'd0,   8'h00);
      send_item(OP_RETRIEVE, 1'b1, 9'd1,   8'h00);
      // oversize insert, cut short by a new burst, which an index reset then ends
      send_item(OP_INSERT,   1'b1, 9'd511, 8'h11);
      send_item(OP_INSERT,   1'b0, 9'd0,   8'h22);
      send_item(OP_INSERT,   1'b1, 9'd2,   8'h5A);
      send_item(OP_RESET,    1'b0, 9'd0,   8'h00);
      send_item(OP_RESET,    1'b1, 9'd256, 8'hFF);
      items_sent += 19;

      // capacity of zero behaves as one
      write_capacity(0);
      send_item(OP_INSERT,   1'b1, 9'd1, 8'hC3);
      send_item(OP_INSERT,   1'b1, 9'd1, 8'h3C);
      send_item(OP_PEEK,     1'b1, 9'd1, 8'h00);
      send_item(OP_RETRIEVE, 1'b1, 9'd1, 8'h00);
      items_sent += 4;

      foreach (cap_plan[p]) begin
         write_capacity(cap_plan[p]);
         if (p == 3 || p == 5) stall_asked++;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) gen_burst();
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d transactions over %0d capacity settings in %0d cycles",
               items_sent, n_settings, cycle_count);
      $display("Checked %0d responses: %0d zero-length, %0d out of memory, %0d bursts closed",
               n_checked, n_bad, n_oom, n_done);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
